// File: rtl/core/bncc_pkg.sv
// ----------------------------------------------------------------------------
// bncc_pkg: shared constants and types of the contingency counter
// Table sizes, field widths, operation codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package bncc_pkg;

    localparam int MAX_PARENTS   = 4;
    localparam int MAX_STATES    = 16;
    localparam int MAX_CONFIGS   = 256;
    localparam int PARENT_FIELDS = 4;
    localparam int USED_PARENTS  = (MAX_PARENTS < PARENT_FIELDS) ? MAX_PARENTS : PARENT_FIELDS;

    // Item and register field widths
    localparam int OP_W       = 2;
    localparam int VAL_W      = 4;
    localparam int RCFG_W     = 8;
    localparam int RADIX_W    = 8;
    localparam int NP_W       = 3;
    localparam int ARITY_W    = 5;
    localparam int COUNT_W    = 32;
    localparam int REG_IDX_W  = 3;
    localparam int REG_DATA_W = 8;

    // Store geometry
    localparam int CFG_ADDR_W   = $clog2(MAX_CONFIGS);
    localparam int ST_ADDR_W    = $clog2(MAX_STATES);
    localparam int JOINT_ADDR_W = CFG_ADDR_W + ST_ADDR_W;
    localparam int JOINT_DEPTH  = MAX_CONFIGS * MAX_STATES;

    // Index accumulator: sum of PARENT_FIELDS products of value and radix
    localparam int PROD_W     = VAL_W + RADIX_W;
    localparam int ACC_W      = PROD_W + $clog2(PARENT_FIELDS);
    localparam int STEP_W     = $clog2(PARENT_FIELDS + 1);
    localparam int STEP_IDX_W = $clog2(PARENT_FIELDS);

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ACCUM = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_NUM_PARENTS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CHILD_ARITY = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RADIX_0     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RADIX_1     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RADIX_2     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RADIX_3     = 3'd5;

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [VAL_W-1:0]   t_value;

endpackage

`default_nettype wire

// File: rtl/core/bncc_in_if.sv
// ----------------------------------------------------------------------------
// bncc_in_if: item channel of the contingency counter
// Valid/ready channel carrying one operation with its row or cell fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface bncc_in_if;
    logic                          valid;
    logic                          ready;
    logic [bncc_pkg::OP_W-1:0]     operation;
    bncc_pkg::t_value              child_value;
    bncc_pkg::t_value              parent_value_0;
    bncc_pkg::t_value              parent_value_1;
    bncc_pkg::t_value              parent_value_2;
    bncc_pkg::t_value              parent_value_3;
    logic [bncc_pkg::RCFG_W-1:0]   read_config;
    bncc_pkg::t_value              read_state;

    modport source (
        output valid, operation, child_value, parent_value_0, parent_value_1,
               parent_value_2, parent_value_3, read_config, read_state,
        input  ready
    );
    modport sink (
        input  valid, operation, child_value, parent_value_0, parent_value_1,
               parent_value_2, parent_value_3, read_config, read_state,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/bncc_out_if.sv
// ----------------------------------------------------------------------------
// bncc_out_if: result channel of the contingency counter
// Valid/ready channel carrying both counts of one cell and an error flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface bncc_out_if;
    logic               valid;
    logic               ready;
    bncc_pkg::t_count   joint_count;
    bncc_pkg::t_count   config_count;
    logic               index_error;

    modport source (
        output valid, joint_count, config_count, index_error,
        input  ready
    );
    modport sink (
        input  valid, joint_count, config_count, index_error,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/bncc_cfg_if.sv
// ----------------------------------------------------------------------------
// bncc_cfg_if: register write channel of the contingency counter
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface bncc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bncc_pkg::REG_IDX_W-1:0]    index;
    logic [bncc_pkg::REG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bayes_net_contingency_counter.sv
// ----------------------------------------------------------------------------
// bayes_net_contingency_counter: count tables for scoring a network node
// Accumulates joint and per-configuration counts, reads and clears them.
// ----------------------------------------------------------------------------
// One item is worked at a time; the item channel is ready only when the block
// is idle and its result register is empty. An accumulate row forms its
// configuration index with one shared 4x8 multiply-accumulate, one parent per
// cycle, then reads both count memories and writes them back; num_parents is
// capped at 4. A read passes through the read and update states.
// A clear, and the clearing pass after reset, sweep the 4096-entry joint
// store one entry per cycle (the configuration store is zeroed alongside), so
// a clear answers once the sweep ends and no item is taken until the sweep
// after reset ends. Register writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bayes_net_contingency_counter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bncc_in_if.sink      i_item,
    bncc_out_if.source   o_result,
    bncc_cfg_if.sink     i_cfg
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_MAC    = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;

    localparam int NPF = bncc_pkg::PARENT_FIELDS;

    logic [2:0]                          r_state;
    logic [bncc_pkg::JOINT_ADDR_W-1:0]   r_sweep;
    logic                                r_clr_reply;

    logic [bncc_pkg::NP_W-1:0]           r_num_parents;
    logic [bncc_pkg::ARITY_W-1:0]        r_child_arity;
    logic [bncc_pkg::RADIX_W-1:0]        r_radix [NPF];

    bncc_pkg::t_value                    r_pv [NPF];
    bncc_pkg::t_value                    r_child;
    logic                                r_is_accum;
    logic [bncc_pkg::STEP_W-1:0]         r_step;
    logic [bncc_pkg::ACC_W-1:0]          r_acc;
    logic                                r_ok;
    logic [bncc_pkg::JOINT_ADDR_W-1:0]   r_jaddr;
    logic [bncc_pkg::CFG_ADDR_W-1:0]     r_caddr;

    bncc_pkg::t_count                    mem_joint [bncc_pkg::JOINT_DEPTH];
    bncc_pkg::t_count                    mem_config [bncc_pkg::MAX_CONFIGS];
    bncc_pkg::t_count                    r_jrd;
    bncc_pkg::t_count                    r_crd;

    logic                                r_out_valid;
    bncc_pkg::t_count                    r_joint;
    bncc_pkg::t_count                    r_config_cnt;
    logic                                r_err;

    logic                                w_in_fire;
    logic [bncc_pkg::NP_W-1:0]           w_used;
    logic [bncc_pkg::STEP_IDX_W-1:0]     w_idx;
    logic [bncc_pkg::PROD_W-1:0]         w_prod;
    logic [bncc_pkg::ACC_W-1:0]          w_acc_next;
    logic                                w_child_ok;
    logic                                w_read_ok;
    bncc_pkg::t_count                    w_joint_inc;
    bncc_pkg::t_count                    w_config_inc;
    logic                                w_clearing;
    logic                                w_commit;
    logic [bncc_pkg::JOINT_ADDR_W-1:0]   w_j_waddr;
    logic [bncc_pkg::CFG_ADDR_W-1:0]     w_c_waddr;
    bncc_pkg::t_count                    w_j_wdata;
    bncc_pkg::t_count                    w_c_wdata;

    assign i_item.ready = (r_state == S_IDLE) && !r_out_valid;
    assign i_cfg.ready  = 1'b1;
    assign w_in_fire    = i_item.valid && i_item.ready;

    assign o_result.valid        = r_out_valid;
    assign o_result.joint_count  = r_joint;
    assign o_result.config_count = r_config_cnt;
    assign o_result.index_error  = r_err;

    // Shared multiply-accumulate over the used parents
    assign w_used = (r_num_parents > bncc_pkg::NP_W'(bncc_pkg::USED_PARENTS))
                  ? bncc_pkg::NP_W'(bncc_pkg::USED_PARENTS) : r_num_parents;
    assign w_idx      = r_step[bncc_pkg::STEP_IDX_W-1:0];
    assign w_prod     = bncc_pkg::PROD_W'(r_pv[w_idx]) * bncc_pkg::PROD_W'(r_radix[w_idx]);
    assign w_acc_next = r_acc + bncc_pkg::ACC_W'(w_prod);

    assign w_child_ok = bncc_pkg::ARITY_W'(r_child) < r_child_arity;
    assign w_read_ok  = (bncc_pkg::ARITY_W'(i_item.read_state) < r_child_arity)
                     && (bncc_pkg::ACC_W'(i_item.read_config)
                         < bncc_pkg::ACC_W'(bncc_pkg::MAX_CONFIGS));

    // Saturating increments of the fetched counts
    assign w_joint_inc  = (r_jrd == '1) ? r_jrd : r_jrd + 1'b1;
    assign w_config_inc = (r_crd == '1) ? r_crd : r_crd + 1'b1;

    assign w_clearing = (r_state == S_CLEAR);
    assign w_commit   = (r_state == S_UPDATE) && r_ok && r_is_accum;
    assign w_j_waddr  = w_clearing ? r_sweep : r_jaddr;
    assign w_c_waddr  = w_clearing ? bncc_pkg::CFG_ADDR_W'(r_sweep) : r_caddr;
    assign w_j_wdata  = w_clearing ? '0 : w_joint_inc;
    assign w_c_wdata  = w_clearing ? '0 : w_config_inc;

    always_ff @(posedge i_clk) begin
        if (w_clearing || w_commit) begin
            mem_joint[w_j_waddr] <= w_j_wdata;
        end
        r_jrd <= mem_joint[r_jaddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_clearing || w_commit) begin
            mem_config[w_c_waddr] <= w_c_wdata;
        end
        r_crd <= mem_config[r_caddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_sweep       <= '0;
            r_clr_reply   <= 1'b0;
            r_out_valid   <= 1'b0;
            r_num_parents <= '0;
            r_child_arity <= bncc_pkg::ARITY_W'(2);
            r_radix[0]    <= bncc_pkg::RADIX_W'(1);
            r_radix[1]    <= '0;
            r_radix[2]    <= '0;
            r_radix[3]    <= '0;
        end else begin
            if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    bncc_pkg::REG_NUM_PARENTS: r_num_parents <= bncc_pkg::NP_W'(i_cfg.data);
                    bncc_pkg::REG_CHILD_ARITY: r_child_arity <= bncc_pkg::ARITY_W'(i_cfg.data);
                    bncc_pkg::REG_RADIX_0:     r_radix[0] <= bncc_pkg::RADIX_W'(i_cfg.data);
                    bncc_pkg::REG_RADIX_1:     r_radix[1] <= bncc_pkg::RADIX_W'(i_cfg.data);
                    bncc_pkg::REG_RADIX_2:     r_radix[2] <= bncc_pkg::RADIX_W'(i_cfg.data);
                    bncc_pkg::REG_RADIX_3:     r_radix[3] <= bncc_pkg::RADIX_W'(i_cfg.data);
                    default: ;
                endcase
            end

            case (r_state)
                S_CLEAR: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == '1) begin
                        r_state <= S_IDLE;
                        if (r_clr_reply) begin
                            r_clr_reply  <= 1'b0;
                            r_out_valid  <= 1'b1;
                            r_joint      <= '0;
                            r_config_cnt <= '0;
                            r_err        <= 1'b0;
                        end
                    end
                end
                S_IDLE: begin
                    if (w_in_fire) begin
                        case (i_item.operation)
                            bncc_pkg::OP_CLEAR: begin
                                r_sweep     <= '0;
                                r_clr_reply <= 1'b1;
                                r_state     <= S_CLEAR;
                            end
                            bncc_pkg::OP_ACCUM: begin
                                r_pv[0]    <= i_item.parent_value_0;
                                r_pv[1]    <= i_item.parent_value_1;
                                r_pv[2]    <= i_item.parent_value_2;
                                r_pv[3]    <= i_item.parent_value_3;
                                r_child    <= i_item.child_value;
                                r_is_accum <= 1'b1;
                                r_step     <= '0;
                                r_acc      <= '0;
                                r_state    <= S_MAC;
                            end
                            bncc_pkg::OP_READ: begin
                                r_is_accum <= 1'b0;
                                r_ok       <= w_read_ok;
                                r_caddr    <= bncc_pkg::CFG_ADDR_W'(i_item.read_config);
                                r_jaddr    <= {bncc_pkg::CFG_ADDR_W'(i_item.read_config),
                                               bncc_pkg::ST_ADDR_W'(i_item.read_state)};
                                r_state    <= S_READ;
                            end
                            default: begin
                                // unknown operation: answer all zero at once
                                r_out_valid  <= 1'b1;
                                r_joint      <= '0;
                                r_config_cnt <= '0;
                                r_err        <= 1'b0;
                            end
                        endcase
                    end
                end
                S_MAC: begin
                    if (bncc_pkg::NP_W'(r_step) == w_used) begin
                        r_ok    <= (r_acc < bncc_pkg::ACC_W'(bncc_pkg::MAX_CONFIGS))
                                && w_child_ok;
                        r_caddr <= bncc_pkg::CFG_ADDR_W'(r_acc);
                        r_jaddr <= {bncc_pkg::CFG_ADDR_W'(r_acc),
                                    bncc_pkg::ST_ADDR_W'(r_child)};
                        r_state <= S_READ;
                    end else begin
                        r_acc  <= w_acc_next;
                        r_step <= r_step + 1'b1;
                    end
                end
                S_READ: begin
                    // memory read data lands next cycle
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                    if (r_ok) begin
                        r_joint      <= r_is_accum ? w_joint_inc : r_jrd;
                        r_config_cnt <= r_is_accum ? w_config_inc : r_crd;
                        r_err        <= 1'b0;
                    end else begin
                        r_joint      <= '0;
                        r_config_cnt <= '0;
                        r_err        <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bncc_checker.sv
// ----------------------------------------------------------------------------
// bncc_checker: port-level checks of the contingency counter
// Watches the item and result channels and the count relations they show.
// ----------------------------------------------------------------------------
`default_nettype none

module bncc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire bncc_pkg::t_count   i_joint_count,
    input wire bncc_pkg::t_count   i_config_count,
    input wire logic               i_index_error
);

    // Item channel opens only once the result register is empty
    a_ready_needs_empty_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |-> !i_out_valid)
        else $error("item channel ready while a result is pending");

    // One item at a time: busy right after a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item channel ready right after a transaction");

    a_error_zero_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_index_error |-> (i_joint_count == '0) && (i_config_count == '0))
        else $error("error result carries nonzero counts");

    // A cell never counts more rows than its configuration
    a_joint_le_config: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_index_error |-> i_joint_count <= i_config_count)
        else $error("joint count exceeds configuration count");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_joint_count)
            && $stable(i_config_count) && $stable(i_index_error))
        else $error("stalled result changed or dropped");

endmodule

bind bayes_net_contingency_counter bncc_checker u_bncc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_joint_count  (o_result.joint_count),
    .i_config_count (o_result.config_count),
    .i_index_error  (o_result.index_error)
);

`default_nettype wire
